@@ rtl/rrs_pkg.sv @@
// Shared types and constants for the round-robin scheduler core.
// Holds the input and result beat structs, command and status codes and
// the configuration register map. No dependencies.
`default_nettype none

package rrs_pkg;

  // Fixed widths of the beat fields
  localparam int TAG_W    = 16;
  localparam int IDX_W    = 6;
  localparam int MASK_W   = 8;
  localparam int SLOT_W   = 3;
  localparam int OTIME_W  = 32;
  localparam int STATUS_W = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int CPU_CNT_W  = 4;
  localparam int SLICE_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CPU_COUNT    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_LENGTH = 4'd1;

  localparam logic [CPU_CNT_W-1:0] CPU_COUNT_RST    = 4'd1;
  localparam logic [SLICE_W-1:0]   SLICE_LENGTH_RST = 16'd10;

  // Commands
  localparam logic [1:0] CMD_SUBMIT   = 2'd0;
  localparam logic [1:0] CMD_DISPATCH = 2'd1;
  localparam logic [1:0] CMD_END      = 2'd2;
  localparam logic [1:0] CMD_READ     = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] STS_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STS_QUEUE_EMPTY = 3'd1;
  localparam logic [STATUS_W-1:0] STS_TABLE_FULL = 3'd2;
  localparam logic [STATUS_W-1:0] STS_BAD_INDEX  = 3'd3;
  localparam logic [STATUS_W-1:0] STS_NO_SLICE   = 3'd4;

  typedef struct packed {
    logic [1:0]        command;
    logic [TAG_W-1:0]  task_tag;
    logic [IDX_W-1:0]  entry_index;
    logic [MASK_W-1:0] finished_mask;
  } in_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]    granted_tag;
    logic [SLOT_W-1:0]   cpu_slot;
    logic [OTIME_W-1:0]  run_time;
    logic [OTIME_W-1:0]  wait_time;
    logic [STATUS_W-1:0] status;
    logic                last;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/rrs_mod_unit.sv @@
// Iterative remainder unit: one restoring step per cycle.
// Used to find the first dispatch position, front mod queue count.
// No package dependencies.
`default_nettype none

module rrs_mod_unit #(
  parameter int DW = 6,
  parameter int RW = 7
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [RW-1:0] divisor_i,
  output logic               busy_o,
  output logic [RW-1:0]      rem_o
);

  localparam int CNTW = $clog2(DW + 1);

  logic            busy_q, busy_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [DW-1:0]   dvd_q, dvd_d;
  logic [RW-1:0]   div_q, div_d;
  logic [RW-1:0]   rem_q, rem_d;
  logic [RW:0]     trial;
  logic [RW:0]     diff;

  assign trial = {rem_q, dvd_q[DW-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNTW'(DW);
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = (trial >= {1'b0, div_q}) ? diff[RW-1:0] : trial[RW-1:0];
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

@@ rtl/rrs_sat_add.sv @@
// Saturating time accumulator shared by run and wait time updates.
// Adds the slice length to a stored time, clamping at all ones.
// Depends on rrs_pkg for the slice width.
`default_nettype none

module rrs_sat_add #(
  parameter int TW = 32
) (
  input  wire logic [TW-1:0]               base_i,
  input  wire logic [rrs_pkg::SLICE_W-1:0] inc_i,
  output logic [TW-1:0]                    sum_o
);

  logic [TW:0] sum;

  assign sum   = {1'b0, base_i} + (TW + 1)'(inc_i);
  assign sum_o = sum[TW] ? '1 : sum[TW-1:0];

endmodule

`default_nettype wire

@@ rtl/multi_cpu_round_robin_scheduler_core.sv @@
// Round-robin multi-CPU scheduler core: sequencer, task table and ready queue.
// Depends on rrs_pkg, rrs_mod_unit and rrs_sat_add.
//
// Usage:
//   in channel  : one command beat (submit, dispatch, end slice, read entry).
//   out channel : result beats; dispatch gives one beat per grant, every other
//                 command gives one beat. The final beat of a command has last=1.
//   cfg channel : register writes (index 0 cpu_count, 1 slice_length), always
//                 ready; write only while no command is in flight.
// Steps from accept to result register, receiver not stalling:
//   submit, read, rejected commands : the response state
//   dispatch    : log2(QUEUE_DEPTH) remainder steps, then per grant a queue
//                 read, a table read and the grant beat
//   end slice   : per table entry a read and a write (time update), then per
//                 queued task queue read, table read, queue write (compaction).
// Flow: one command at a time; in_ready_o is high only in idle. The end-slice
// walk and compaction step entry by entry through one-read, one-write memories.
// Reset: queue and table empty, no slice open, cpu_count 1, slice_length 10.
// No clearing pass is needed: table entries are only read below the fill count.
// Stall: a result sits in the output register until taken; the sequencer holds
// its state meanwhile and resumes when the register frees.
`default_nettype none

module multi_cpu_round_robin_scheduler_core #(
  parameter int QUEUE_DEPTH = 64,
  parameter int MAX_CPUS    = 8,
  parameter int TIME_BITS   = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire rrs_pkg::in_item_t                  in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output rrs_pkg::out_item_t                      out_data_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [rrs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [rrs_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // Entry/queue position width, fill-count width, grant counters
  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int GCW = $clog2(MAX_CPUS + 1);
  localparam int GIW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int IW  = (CW > rrs_pkg::IDX_W) ? CW : rrs_pkg::IDX_W;
  localparam int NW  = (CW > 5) ? CW : 5;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_RESP   = 11'b000_0000_0010,
    ST_DS_MOD = 11'b000_0000_0100,
    ST_DS_Q   = 11'b000_0000_1000,
    ST_DS_T   = 11'b000_0001_0000,
    ST_DS_OUT = 11'b000_0010_0000,
    ST_ES_RD  = 11'b000_0100_0000,
    ST_ES_WR  = 11'b000_1000_0000,
    ST_CP_Q   = 11'b001_0000_0000,
    ST_CP_R   = 11'b010_0000_0000,
    ST_CP_W   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration
  logic [rrs_pkg::CPU_CNT_W-1:0] cpu_q;
  logic [rrs_pkg::SLICE_W-1:0]   slice_q;

  // Scheduler state
  logic [CW-1:0]  qc_q, qc_d;        // queue count
  logic [QW-1:0]  front_q, front_d;
  logic [CW-1:0]  ec_q, ec_d;        // table entry count
  logic [GCW-1:0] gc_q, gc_d;        // granted count, 0 = no slice open
  logic [QW-1:0]  gent_q [MAX_CPUS];
  logic           gent_we;

  // Sequencer working registers
  logic [GCW-1:0]               n_q, n_d;
  logic [GCW-1:0]               gi_q, gi_d;
  logic [QW-1:0]                pos_q, pos_d;
  logic [QW-1:0]                cnt_q, cnt_d;
  logic [CW-1:0]                keep_q, keep_d;
  logic [rrs_pkg::MASK_W-1:0]   mask_q, mask_d;
  logic [rrs_pkg::STATUS_W-1:0] rsts_q, rsts_d;
  logic                         rrd_q, rrd_d;   // response carries table data

  // Output register
  logic               out_valid_q;
  rrs_pkg::out_item_t out_data_q;
  logic               emit;
  rrs_pkg::out_item_t emit_data;
  logic               can_emit;

  // Memories and their ports
  logic [QW-1:0]                q_mem    [QUEUE_DEPTH];
  logic [rrs_pkg::TAG_W-1:0]    tag_mem  [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]         run_mem  [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]         wait_mem [QUEUE_DEPTH];
  logic                         rdy_mem  [QUEUE_DEPTH];

  logic                      q_re, q_we;
  logic [QW-1:0]             q_raddr, q_waddr, q_wdata, q_rd_q;
  logic                      ent_re, ent_we, tag_we;
  logic [QW-1:0]             ent_raddr, ent_waddr;
  logic [rrs_pkg::TAG_W-1:0] tag_wdata, tag_rd_q;
  logic [TIME_BITS-1:0]      run_wdata, wait_wdata, run_rd_q, wait_rd_q;
  logic                      rdy_wdata, rdy_rd_q;

  // Shared units
  logic                 mod_start, mod_busy;
  logic [CW-1:0]        mod_rem;
  logic [TIME_BITS-1:0] sat_base, sat_sum;

  // Grant lookup for the entry under update
  logic is_granted, is_finished;

  // Misc combinational
  logic          in_acc;
  logic [IW-1:0] idx_ext;
  logic [NW-1:0] cpu_eff, n_calc;
  logic [CW-1:0] keep_n;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign can_emit    = !out_valid_q || out_ready_i;
  assign idx_ext     = IW'(in_data_i.entry_index);

  // cpu_count of 0 means one, above MAX_CPUS clamps; then limit to queue count
  always_comb begin
    if (cpu_q == '0) begin
      cpu_eff = NW'(1);
    end else if (NW'(cpu_q) > NW'(MAX_CPUS)) begin
      cpu_eff = NW'(MAX_CPUS);
    end else begin
      cpu_eff = NW'(cpu_q);
    end
    n_calc = (cpu_eff > NW'(qc_q)) ? NW'(qc_q) : cpu_eff;
  end

  always_comb begin
    is_granted  = 1'b0;
    is_finished = 1'b0;
    for (int g = 0; g < MAX_CPUS; g++) begin
      if ((GCW'(g) < gc_q) && (gent_q[g] == cnt_q)) begin
        is_granted = 1'b1;
        if ((g < rrs_pkg::MASK_W) && mask_q[3'(g)]) begin
          is_finished = 1'b1;
        end
      end
    end
  end

  assign sat_base = is_granted ? run_rd_q : wait_rd_q;
  assign keep_n   = keep_q + CW'(rdy_rd_q);

  rrs_mod_unit #(
    .DW (QW),
    .RW (CW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (front_q),
    .divisor_i  (qc_q),
    .busy_o     (mod_busy),
    .rem_o      (mod_rem)
  );

  rrs_sat_add #(
    .TW (TIME_BITS)
  ) u_sat (
    .base_i (sat_base),
    .inc_i  (slice_q),
    .sum_o  (sat_sum)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    qc_d    = qc_q;
    front_d = front_q;
    ec_d    = ec_q;
    gc_d    = gc_q;
    n_d     = n_q;
    gi_d    = gi_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    keep_d  = keep_q;
    mask_d  = mask_q;
    rsts_d  = rsts_q;
    rrd_d   = rrd_q;

    gent_we   = 1'b0;
    mod_start = 1'b0;
    emit      = 1'b0;
    emit_data = '0;

    q_re       = 1'b0;
    q_raddr    = pos_q;
    q_we       = 1'b0;
    q_waddr    = keep_q[QW-1:0];
    q_wdata    = q_rd_q;
    ent_re     = 1'b0;
    ent_raddr  = cnt_q;
    ent_we     = 1'b0;
    tag_we     = 1'b0;
    ent_waddr  = cnt_q;
    tag_wdata  = in_data_i.task_tag;
    run_wdata  = '0;
    wait_wdata = '0;
    rdy_wdata  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          rrd_d   = 1'b0;
          rsts_d  = rrs_pkg::STS_OK;
          state_d = ST_RESP;
          case (in_data_i.command)
            rrs_pkg::CMD_SUBMIT: begin
              if (ec_q == CW'(QUEUE_DEPTH)) begin
                rsts_d = rrs_pkg::STS_TABLE_FULL;
              end else begin
                // new entry: zero times, ready, appended to the queue tail
                tag_we     = 1'b1;
                ent_we     = 1'b1;
                ent_waddr  = ec_q[QW-1:0];
                run_wdata  = '0;
                wait_wdata = '0;
                rdy_wdata  = 1'b1;
                if (qc_q != CW'(QUEUE_DEPTH)) begin
                  q_we    = 1'b1;
                  q_waddr = qc_q[QW-1:0];
                  q_wdata = ec_q[QW-1:0];
                  qc_d    = qc_q + CW'(1);
                end
                ec_d = ec_q + CW'(1);
              end
            end
            rrs_pkg::CMD_DISPATCH: begin
              gc_d = '0;  // any open slice is dropped
              if (qc_q == '0) begin
                rsts_d = rrs_pkg::STS_QUEUE_EMPTY;
              end else begin
                mod_start = 1'b1;
                n_d       = GCW'(n_calc);
                state_d   = ST_DS_MOD;
              end
            end
            rrs_pkg::CMD_END: begin
              if (gc_q == '0) begin
                rsts_d = rrs_pkg::STS_NO_SLICE;
              end else begin
                mask_d  = in_data_i.finished_mask;
                cnt_d   = '0;
                state_d = ST_ES_RD;
              end
            end
            rrs_pkg::CMD_READ: begin
              if ((idx_ext >= IW'(ec_q)) || (idx_ext >= IW'(QUEUE_DEPTH))) begin
                rsts_d = rrs_pkg::STS_BAD_INDEX;
              end else begin
                ent_re    = 1'b1;
                ent_raddr = idx_ext[QW-1:0];
                rrd_d     = 1'b1;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_RESP: begin
        if (can_emit) begin
          emit                  = 1'b1;
          emit_data.status      = rsts_q;
          emit_data.last        = 1'b1;
          if (rrd_q) begin
            emit_data.granted_tag = tag_rd_q;
            emit_data.run_time    = rrs_pkg::OTIME_W'(run_rd_q);
            emit_data.wait_time   = rrs_pkg::OTIME_W'(wait_rd_q);
          end
          state_d = ST_IDLE;
        end
      end

      ST_DS_MOD: begin
        if (!mod_busy) begin
          pos_d   = mod_rem[QW-1:0];
          gi_d    = '0;
          state_d = ST_DS_Q;
        end
      end

      ST_DS_Q: begin
        q_re    = 1'b1;
        q_raddr = pos_q;
        state_d = ST_DS_T;
      end

      ST_DS_T: begin
        gent_we   = 1'b1;
        ent_re    = 1'b1;
        ent_raddr = q_rd_q;
        state_d   = ST_DS_OUT;
      end

      ST_DS_OUT: begin
        if (can_emit) begin
          emit                  = 1'b1;
          emit_data.granted_tag = tag_rd_q;
          emit_data.cpu_slot    = rrs_pkg::SLOT_W'(gi_q);
          emit_data.status      = rrs_pkg::STS_OK;
          emit_data.last        = ((gi_q + GCW'(1)) == n_q);
          if ((gi_q + GCW'(1)) == n_q) begin
            gc_d    = n_q;
            state_d = ST_IDLE;
          end else begin
            gi_d    = gi_q + GCW'(1);
            pos_d   = ((CW'(pos_q) + CW'(1)) == qc_q) ? '0 : pos_q + QW'(1);
            state_d = ST_DS_Q;
          end
        end
      end

      // Time accounting walk over the table
      ST_ES_RD: begin
        ent_re    = 1'b1;
        ent_raddr = cnt_q;
        state_d   = ST_ES_WR;
      end

      ST_ES_WR: begin
        ent_we     = 1'b1;
        ent_waddr  = cnt_q;
        run_wdata  = is_granted ? sat_sum : run_rd_q;
        wait_wdata = (!is_granted && rdy_rd_q) ? sat_sum : wait_rd_q;
        rdy_wdata  = rdy_rd_q && !is_finished;
        if ((CW'(cnt_q) + CW'(1)) == ec_q) begin
          cnt_d   = '0;
          keep_d  = '0;
          state_d = ST_CP_Q;
        end else begin
          cnt_d   = cnt_q + QW'(1);
          state_d = ST_ES_RD;
        end
      end

      // Queue compaction: keep entries still ready, in order
      ST_CP_Q: begin
        q_re    = 1'b1;
        q_raddr = cnt_q;
        state_d = ST_CP_R;
      end

      ST_CP_R: begin
        ent_re    = 1'b1;
        ent_raddr = q_rd_q;
        state_d   = ST_CP_W;
      end

      ST_CP_W: begin
        q_we    = rdy_rd_q;
        q_waddr = keep_q[QW-1:0];
        q_wdata = q_rd_q;
        if ((CW'(cnt_q) + CW'(1)) == qc_q) begin
          qc_d = keep_n;
          if (keep_n != '0) begin
            front_d = ((CW'(front_q) + CW'(1)) == CW'(QUEUE_DEPTH)) ?
                      '0 : front_q + QW'(1);
          end
          gc_d    = '0;
          rsts_d  = rrs_pkg::STS_OK;
          rrd_d   = 1'b0;
          state_d = ST_RESP;
        end else begin
          cnt_d   = cnt_q + QW'(1);
          keep_d  = keep_n;
          state_d = ST_CP_Q;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cpu_q       <= rrs_pkg::CPU_COUNT_RST;
      slice_q     <= rrs_pkg::SLICE_LENGTH_RST;
      qc_q        <= '0;
      front_q     <= '0;
      ec_q        <= '0;
      gc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      qc_q    <= qc_d;
      front_q <= front_d;
      ec_q    <= ec_d;
      gc_q    <= gc_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          rrs_pkg::CFG_CPU_COUNT:    cpu_q   <= cfg_data_i[rrs_pkg::CPU_CNT_W-1:0];
          rrs_pkg::CFG_SLICE_LENGTH: slice_q <= cfg_data_i[rrs_pkg::SLICE_W-1:0];
          default: begin
          end
        endcase
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working and payload registers
  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    gi_q   <= gi_d;
    pos_q  <= pos_d;
    cnt_q  <= cnt_d;
    keep_q <= keep_d;
    mask_q <= mask_d;
    rsts_q <= rsts_d;
    rrd_q  <= rrd_d;
    if (gent_we) begin
      gent_q[gi_q[GIW-1:0]] <= q_rd_q;
    end
    if (emit) begin
      out_data_q <= emit_data;
    end
  end

  // Ready queue memory
  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      q_rd_q <= q_mem[q_raddr];
    end
  end

  // Task table memories
  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[ent_waddr] <= tag_wdata;
    end
    if (ent_we) begin
      run_mem[ent_waddr]  <= run_wdata;
      wait_mem[ent_waddr] <= wait_wdata;
      rdy_mem[ent_waddr]  <= rdy_wdata;
    end
    if (ent_re) begin
      tag_rd_q  <= tag_mem[ent_raddr];
      run_rd_q  <= run_mem[ent_raddr];
      wait_rd_q <= wait_mem[ent_raddr];
      rdy_rd_q  <= rdy_mem[ent_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

@@ sim/rrs_sched_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the round-robin scheduler core: watches the command, result
// and register channels, predicts every result beat and compares it.
// Depends on rrs_pkg.
module rrs_sched_checker
  import rrs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int MAX_CPUS    = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_item_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_item_t             out_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    beats_o
);

  // Shadow registers
  logic [CPU_CNT_W-1:0] cpus_reg;
  logic [SLICE_W-1:0]   slice_reg;

  // Shadow scheduler state
  int                 run_order[QUEUE_DEPTH];
  int                 run_len;
  int                 run_head;
  int                 tbl_fill;
  logic [TAG_W-1:0]   tbl_tag[QUEUE_DEPTH];
  logic [OTIME_W-1:0] tbl_run[QUEUE_DEPTH];
  logic [OTIME_W-1:0] tbl_wait[QUEUE_DEPTH];
  bit                 tbl_ready[QUEUE_DEPTH];
  int                 slice_grants[MAX_CPUS];
  int                 n_grants;

  out_item_t due_beats[$];
  out_item_t exp_beat;
  int        n_fail  = 0;
  int        n_beats = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    beats_o      = 0;
  end

  function automatic logic [OTIME_W-1:0] add_sat(logic [OTIME_W-1:0] a, logic [SLICE_W-1:0] b);
    logic [OTIME_W:0] s;
    s = {1'b0, a} + b;
    return s[OTIME_W] ? '1 : s[OTIME_W-1:0];
  endfunction

  function automatic out_item_t beat_of(logic [TAG_W-1:0] tg, int slot, logic [OTIME_W-1:0] rt,
                                        logic [OTIME_W-1:0] wt, logic [STATUS_W-1:0] st,
                                        logic lst);
    out_item_t r;
    r.granted_tag = tg;
    r.cpu_slot    = SLOT_W'(slot);
    r.run_time    = rt;
    r.wait_time   = wt;
    r.status      = st;
    r.last        = lst;
    return r;
  endfunction

  function automatic void sched_reset();
    cpus_reg  = CPU_COUNT_RST;
    slice_reg = SLICE_LENGTH_RST;
    run_len   = 0;
    run_head  = 0;
    tbl_fill  = 0;
    n_grants  = 0;
    foreach (tbl_ready[i]) tbl_ready[i] = 1'b0;
    due_beats.delete();
  endfunction

  // Expected beats of one accepted command, appended in order
  function automatic void schedule_command(in_item_t c);
    int  n;
    int  e;
    int  keep;
    bit  hit;
    case (c.command)
      CMD_SUBMIT: begin
        if (tbl_fill >= QUEUE_DEPTH) begin
          due_beats.push_back(beat_of('0, 0, '0, '0, STS_TABLE_FULL, 1'b1));
        end else begin
          e              = tbl_fill;
          tbl_tag[e]     = c.task_tag;
          tbl_run[e]     = '0;
          tbl_wait[e]    = '0;
          tbl_ready[e]   = 1'b1;
          if (run_len < QUEUE_DEPTH) begin
            run_order[run_len] = e;
            run_len++;
          end
          tbl_fill++;
          due_beats.push_back(beat_of('0, 0, '0, '0, STS_OK, 1'b1));
        end
      end
      CMD_DISPATCH: begin
        n = int'(cpus_reg);
        if (n < 1) n = 1;
        if (n > MAX_CPUS) n = MAX_CPUS;
        // an open slice is dropped without accounting
        n_grants = 0;
        if (run_len == 0) begin
          due_beats.push_back(beat_of('0, 0, '0, '0, STS_QUEUE_EMPTY, 1'b1));
        end else begin
          if (n > run_len) n = run_len;
          for (int i = 0; i < n; i++) begin
            e               = run_order[(run_head + i) % run_len];
            slice_grants[i] = e;
            due_beats.push_back(beat_of(tbl_tag[e], i, '0, '0, STS_OK, i == n - 1));
          end
          n_grants = n;
        end
      end
      CMD_END: begin
        if (n_grants == 0) begin
          due_beats.push_back(beat_of('0, 0, '0, '0, STS_NO_SLICE, 1'b1));
        end else begin
          for (int i = 0; i < tbl_fill; i++) begin
            hit = 1'b0;
            for (int g = 0; g < n_grants; g++)
              if (slice_grants[g] == i) hit = 1'b1;
            if (hit) tbl_run[i] = add_sat(tbl_run[i], slice_reg);
            else if (tbl_ready[i]) tbl_wait[i] = add_sat(tbl_wait[i], slice_reg);
          end
          // mask bits past the grant count fall out here
          for (int g = 0; g < n_grants && g < MASK_W; g++)
            if (c.finished_mask[g]) tbl_ready[slice_grants[g]] = 1'b0;
          keep = 0;
          for (int i = 0; i < run_len; i++) begin
            if (tbl_ready[run_order[i]]) begin
              run_order[keep] = run_order[i];
              keep++;
            end
          end
          run_len = keep;
          if (run_len > 0) run_head = (run_head + 1) % QUEUE_DEPTH;
          n_grants = 0;
          due_beats.push_back(beat_of('0, 0, '0, '0, STS_OK, 1'b1));
        end
      end
      CMD_READ: begin
        e = int'(c.entry_index);
        if (e >= tbl_fill) begin
          due_beats.push_back(beat_of('0, 0, '0, '0, STS_BAD_INDEX, 1'b1));
        end else begin
          due_beats.push_back(beat_of(tbl_tag[e], 0, tbl_run[e], tbl_wait[e], STS_OK, 1'b1));
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void flag_beat(string what, out_item_t want, out_item_t got);
    n_fail++;
    if (n_fail <= 10)
      $display("%0t %s: want tag=%h slot=%0d run=%0d wait=%0d st=%0d last=%0b | got tag=%h slot=%0d run=%0d wait=%0d st=%0d last=%0b",
               $time, what, want.granted_tag, want.cpu_slot, want.run_time, want.wait_time,
               want.status, want.last, got.granted_tag, got.cpu_slot, got.run_time,
               got.wait_time, got.status, got.last);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sched_reset();
    end else begin
      // older beats leave before a new command's beats are queued
      if (out_valid_i && out_ready_i) begin
        n_beats++;
        if (due_beats.size() == 0) begin
          flag_beat("unexpected beat", '0, out_data_i);
        end else begin
          exp_beat = due_beats.pop_front();
          if (out_data_i.granted_tag !== exp_beat.granted_tag ||
              out_data_i.cpu_slot    !== exp_beat.cpu_slot    ||
              out_data_i.run_time    !== exp_beat.run_time    ||
              out_data_i.wait_time   !== exp_beat.wait_time   ||
              out_data_i.status      !== exp_beat.status      ||
              out_data_i.last        !== exp_beat.last)
            flag_beat("beat mismatch", exp_beat, out_data_i);
        end
      end
      if (in_valid_i && in_ready_i) schedule_command(in_data_i);
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_CPU_COUNT) cpus_reg = cfg_data_i[CPU_CNT_W-1:0];
        else if (cfg_index_i == CFG_SLICE_LENGTH) slice_reg = cfg_data_i[SLICE_W-1:0];
      end
    end
    fail_count_o <= n_fail;
    pending_o    <= due_beats.size();
    beats_o      <= n_beats;
  end

endmodule

@@ sim/multi_cpu_round_robin_scheduler_core_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the round-robin scheduler core: drives command beats,
// register writes and result back-pressure, and gives the verdict.
// Depends on rrs_pkg, rrs_sched_checker and the core.
module multi_cpu_round_robin_scheduler_core_tb;
  import rrs_pkg::*;

  localparam int QUEUE_DEPTH = 64;
  localparam int MAX_CPUS    = 8;
  localparam int TIME_BITS   = 32;

  // Index outside the register map; a write to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 4'd15;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int fail_count;
  int pending;
  int beats_seen;

  // Stimulus bookkeeping
  bit steady       = 1'b0;  // no sender gaps, receiver always ready
  int submits_sent = 0;
  int cmd_seen[4]  = '{0, 0, 0, 0};
  int n_settings   = 0;

  always #2 clk_i = ~clk_i;

  multi_cpu_round_robin_scheduler_core #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_CPUS    (MAX_CPUS),
    .TIME_BITS   (TIME_BITS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  rrs_sched_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_CPUS    (MAX_CPUS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .beats_o      (beats_seen)
  );

  // Result side: stalls with a chance of 37 in 100, never while steady.
  // A fresh draw every cycle lands stalls on every phase of a dispatch
  // burst and on the single beats of the other commands.
  always @(posedge clk_i) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 37);
  end

  // One command beat. Unused fields carry random bits so that every input
  // bit toggles. Valid stays high across back-to-back beats; it is lowered
  // only when a gap is drawn, in the step the previous beat was taken.
  task automatic send_op(input logic [1:0] op, input logic [TAG_W-1:0] arg);
    in_item_t b;
    b         = in_item_t'($urandom);
    b.command = op;
    case (op)
      CMD_SUBMIT: b.task_tag      = arg;
      CMD_READ:   b.entry_index   = arg[IDX_W-1:0];
      CMD_END:    b.finished_mask = arg[MASK_W-1:0];
      default: ;
    endcase
    if (!steady && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk_i); while (!in_ready);
    cmd_seen[op]++;
    if (op == CMD_SUBMIT) submits_sent++;
  endtask

  // Stop sending and wait until every predicted beat has come back. Each
  // command yields a beat on completion, so an empty scoreboard means idle;
  // the extra wait at the end is margin before a register write.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // cpu_count write carries random upper data bits; only the low nibble counts
  task automatic set_config(input logic [CPU_CNT_W-1:0] cpus, input logic [SLICE_W-1:0] slice);
    logic [CFG_DATA_W-1:0] d;
    d                = CFG_DATA_W'($urandom);
    d[CPU_CNT_W-1:0] = cpus;
    write_reg(CFG_CPU_COUNT, d);
    write_reg(CFG_SLICE_LENGTH, slice);
    n_settings++;
  endtask

  // Mostly sparse finish masks keep the queue populated; now and then a
  // fully random one
  function automatic logic [MASK_W-1:0] pick_mask();
    logic [MASK_W-1:0] m;
    if ($urandom_range(0, 7) == 0) return MASK_W'($urandom);
    for (int i = 0; i < MASK_W; i++) m[i] = ($urandom_range(0, 3) == 0);
    return m;
  endfunction

  // Reads mostly hit filled entries, the rest any index (possibly bad)
  function automatic logic [TAG_W-1:0] pick_index();
    int hi;
    hi = (submits_sent > QUEUE_DEPTH) ? QUEUE_DEPTH : submits_sent;
    if (hi > 0 && $urandom_range(0, 99) < 70) return TAG_W'($urandom_range(0, hi - 1));
    return TAG_W'($urandom_range(0, QUEUE_DEPTH - 1));
  endfunction

  // Well-formed slice: dispatch, maybe a submit or read while it is open,
  // then end slice
  task automatic run_slice();
    send_op(CMD_DISPATCH, TAG_W'($urandom));
    if ($urandom_range(0, 99) < 40) begin
      if ($urandom_range(0, 1) == 0) send_op(CMD_SUBMIT, TAG_W'($urandom));
      else send_op(CMD_READ, pick_index());
    end
    send_op(CMD_END, TAG_W'(pick_mask()));
  endtask

  // Random traffic: half submits while filling; otherwise mostly whole slices,
  // the rest single commands in any order (stray ends, back-to-back dispatches)
  task automatic random_step(input bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 50) send_op(CMD_SUBMIT, TAG_W'($urandom));
      else if (r < 75) run_slice();
      else send_op(CMD_READ, pick_index());
    end else if (r < 55) begin
      run_slice();
    end else begin
      r = $urandom_range(0, 99);
      if (r < 35) send_op(CMD_SUBMIT, TAG_W'($urandom));
      else if (r < 70) send_op(CMD_READ, pick_index());
      else if (r < 85) send_op(CMD_DISPATCH, TAG_W'($urandom));
      else send_op(CMD_END, TAG_W'(pick_mask()));
    end
  endtask

  initial begin
    int start;
    bit paused;
    bit timed_out;
    int guard;
    timed_out = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset settings (one CPU, slice 10)
    send_op(CMD_END, 16'h00FF);        // no slice open
    send_op(CMD_DISPATCH, 16'h0000);   // empty queue
    send_op(CMD_READ, 16'h0000);       // empty table
    send_op(CMD_READ, 16'h003F);       // top index, still unfilled
    send_op(CMD_SUBMIT, 16'h0000);
    send_op(CMD_SUBMIT, 16'hFFFF);
    send_op(CMD_SUBMIT, 16'hA5A5);
    send_op(CMD_DISPATCH, 16'h0000);
    send_op(CMD_SUBMIT, 16'h5A5A);     // joins while the slice is open
    send_op(CMD_DISPATCH, 16'h0000);   // open slice dropped, regranted
    send_op(CMD_END, 16'h0000);        // nothing finished
    for (int i = 0; i < 4; i++) send_op(CMD_READ, TAG_W'(i));
    send_op(CMD_DISPATCH, 16'h0000);
    send_op(CMD_END, 16'h00FF);        // bits past the grant count ignored
    send_op(CMD_END, 16'h0001);        // slice already closed
    send_op(CMD_READ, 16'h0000);

    // Several CPUs, long slice
    drain_results();
    set_config(4'd3, 16'd1000);
    send_op(CMD_DISPATCH, 16'h0000);
    send_op(CMD_END, 16'h0002);
    send_op(CMD_DISPATCH, 16'h0000);
    send_op(CMD_END, 16'h0080);
    send_op(CMD_READ, 16'h0001);

    // Random phases, each under its own settings; the queue is empty-safe
    // in every phase since the scoreboard is drained before each write
    for (int p = 0; p < 4; p++) begin
      drain_results();
      case (p)
        0: set_config(4'd0, 16'd0);          // treated as one CPU, no time added
        1: set_config(4'd15, 16'd1);         // clamped to the CPU maximum
        2: set_config(CPU_CNT_W'($urandom_range(2, 7)), SLICE_W'($urandom_range(1, 65535)));
        default: set_config(4'd8, 16'hFFFF);
      endcase
      steady = (p == 2);
      paused = 1'b0;
      start  = cmd_seen.sum();
      while (cmd_seen.sum() - start < 40) begin
        // hold the sender off mid-phase until every result is back
        if (p == 1 && !paused && cmd_seen.sum() - start >= 20) begin
          drain_results();
          paused = 1'b1;
        end
        random_step(1'b0);
      end
    end

    // Fill the table past its capacity, with slices and reads interleaved
    drain_results();
    steady = 1'b0;
    set_config(4'd1, 16'd10);
    write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
    while (submits_sent < QUEUE_DEPTH + 3) random_step(1'b1);
    send_op(CMD_READ, TAG_W'(QUEUE_DEPTH - 1));
    run_slice();

    // Wait for the last beats, then long enough for a full end-slice walk
    // so that a stray extra beat would still be seen
    in_valid <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending != 0) timed_out = 1'b1;
    repeat (400) @(posedge clk_i);

    $display("Covered %0d commands: %0d submit, %0d dispatch, %0d end slice, %0d read",
             cmd_seen.sum(), cmd_seen[CMD_SUBMIT], cmd_seen[CMD_DISPATCH],
             cmd_seen[CMD_END], cmd_seen[CMD_READ]);
    $display("%0d result beats checked over %0d register settings, %0d mismatches",
             beats_seen, n_settings, fail_count);
    if (fail_count == 0 && !timed_out) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rrs_pkg.sv
rtl/rrs_mod_unit.sv
rtl/rrs_sat_add.sv
rtl/multi_cpu_round_robin_scheduler_core.sv
sim/rrs_sched_checker.sv
sim/multi_cpu_round_robin_scheduler_core_tb.sv
